>>> sv/pcc_pkg.sv
// Shared constants, types and the direction table of the polygon chain-code generator.
`timescale 1ns / 1ps

package pcc_pkg;

	localparam int COORD_BITS = 14;
	localparam int MAX_SPAN   = 32;

	// span counter holds 0..MAX_SPAN; remainder holds -2*MAX_SPAN..4*MAX_SPAN-1
	localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);
	localparam int R_BITS    = SPAN_BITS + 2;

	localparam int S_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int M_DATA_W = 8;
	localparam int M_USER_W = 2;

	// Freeman directions, y grows downward
	localparam logic [2:0] DIR_E  = 3'd0;
	localparam logic [2:0] DIR_NE = 3'd1;
	localparam logic [2:0] DIR_N  = 3'd2;
	localparam logic [2:0] DIR_NW = 3'd3;
	localparam logic [2:0] DIR_W  = 3'd4;
	localparam logic [2:0] DIR_SW = 3'd5;
	localparam logic [2:0] DIR_S  = 3'd6;
	localparam logic [2:0] DIR_SE = 3'd7;

	// unit moves: bit 1 = positive, bit 0 = negative
	localparam logic [1:0] MV_NONE = 2'b00;
	localparam logic [1:0] MV_NEG  = 2'b01;
	localparam logic [1:0] MV_POS  = 2'b10;

	typedef struct packed {
		logic                        zero;
		logic                        too_long;
		logic signed [R_BITS-1:0]    dx2;
		logic signed [R_BITS-1:0]    dy2;
		logic        [SPAN_BITS-1:0] span;
	} edge_info_t;

	typedef struct packed {
		logic load;
		logic step;
	} dda_ctl_t;

	function automatic logic [2:0] move_code(input logic [1:0] mx, input logic [1:0] my);
		logic [2:0] code;
		case ({mx, my})
			{MV_NEG,  MV_NEG}:  code = DIR_NW;
			{MV_NEG,  MV_NONE}: code = DIR_W;
			{MV_NEG,  MV_POS}:  code = DIR_SW;
			{MV_NONE, MV_NEG}:  code = DIR_N;
			{MV_NONE, MV_POS}:  code = DIR_S;
			{MV_POS,  MV_NEG}:  code = DIR_NE;
			{MV_POS,  MV_POS}:  code = DIR_SE;
			default:            code = DIR_E;
		endcase
		return code;
	endfunction

endpackage

>>> sv/pcc_edge_calc.sv
// Edge setup: deltas, step count and span check of one polygon edge.
`timescale 1ns / 1ps

module pcc_edge_calc import pcc_pkg::*; (
	input  logic [COORD_BITS-1:0] x0,
	input  logic [COORD_BITS-1:0] y0,
	input  logic [COORD_BITS-1:0] x1,
	input  logic [COORD_BITS-1:0] y1,
	output edge_info_t            info
);

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] dx_abs;
	logic signed [COORD_BITS:0] dy_abs;
	logic        [COORD_BITS-1:0] ax;
	logic        [COORD_BITS-1:0] ay;
	logic        [COORD_BITS-1:0] s;

	always_comb begin
		dx     = $signed({1'b0, x1}) - $signed({1'b0, x0});
		dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
		dx_abs = dx[COORD_BITS] ? -dx : dx;
		dy_abs = dy[COORD_BITS] ? -dy : dy;
		ax     = dx_abs[COORD_BITS-1:0];
		ay     = dy_abs[COORD_BITS-1:0];
		s      = (ax > ay) ? ax : ay;

		info.zero     = (s == '0);
		info.too_long = (s > COORD_BITS'(MAX_SPAN));
		// only meaningful when the span fits
		info.dx2      = $signed({dx[SPAN_BITS:0], 1'b0});
		info.dy2      = $signed({dy[SPAN_BITS:0], 1'b0});
		info.span     = s[SPAN_BITS-1:0];
	end

endmodule

>>> sv/pcc_dda.sv
// DDA stepper: per-axis remainder accumulators and step counter, one code per step.
`timescale 1ns / 1ps

module pcc_dda import pcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dda_ctl_t   ctl,
	input  edge_info_t info,
	output logic [2:0] code,
	output logic       last_step
);

	logic signed [R_BITS-1:0]    rx_q;
	logic signed [R_BITS-1:0]    ry_q;
	logic signed [R_BITS-1:0]    dx2_q;
	logic signed [R_BITS-1:0]    dy2_q;
	logic signed [R_BITS-1:0]    two_s_q;
	logic        [SPAN_BITS-1:0] cnt_q;

	logic signed [R_BITS-1:0] sum_x;
	logic signed [R_BITS-1:0] sum_y;
	logic signed [R_BITS-1:0] rx_next;
	logic signed [R_BITS-1:0] ry_next;
	logic        [1:0]        mx;
	logic        [1:0]        my;

	// remainder of (2*k*d + s) / (2*s); quotient moves by at most one per step
	always_comb begin
		sum_x = rx_q + dx2_q;
		sum_y = ry_q + dy2_q;
		if (sum_x >= two_s_q) begin
			mx      = MV_POS;
			rx_next = sum_x - two_s_q;
		end else if (sum_x < 0) begin
			mx      = MV_NEG;
			rx_next = sum_x + two_s_q;
		end else begin
			mx      = MV_NONE;
			rx_next = sum_x;
		end
		if (sum_y >= two_s_q) begin
			my      = MV_POS;
			ry_next = sum_y - two_s_q;
		end else if (sum_y < 0) begin
			my      = MV_NEG;
			ry_next = sum_y + two_s_q;
		end else begin
			my      = MV_NONE;
			ry_next = sum_y;
		end
		code      = move_code(mx, my);
		last_step = (cnt_q == SPAN_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= info.span;
		end else if (ctl.step) begin
			cnt_q <= cnt_q - SPAN_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rx_q    <= $signed(R_BITS'(info.span));
			ry_q    <= $signed(R_BITS'(info.span));
			two_s_q <= $signed(R_BITS'({info.span, 1'b0}));
			dx2_q   <= info.dx2;
			dy2_q   <= info.dy2;
		end else if (ctl.step) begin
			rx_q <= rx_next;
			ry_q <= ry_next;
		end
	end

endmodule

>>> sv/polygon_chain_code_generator.sv
// Top level: vertex store, edge sequencer and output register of the chain-code generator.
//
//  channel | dir | fields
//  s_*     | in  | tdata: vert_x, vert_y; tlast: last_vertex
//  m_*     | out | tdata: dir_code; tuser: closing_edge, span_error; tlast: run_last
//
// An item is accepted in the idle state, then each edge (a zero-length open edge included)
// passes through the setup state and, if it has codes, the step state, where the single DDA
// stepper puts out one code per cycle unless a held result stalls it; an overlong edge puts
// out its error result from the setup state. An opening vertex that emits nothing stays idle.
// s_tready is high only while the sequencer is idle; a held result stalls stepping.
// Reset closes any open polygon.
`timescale 1ns / 1ps

module polygon_chain_code_generator import pcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // vert_x, vert_y, zero pad
	input  logic                s_tlast,   // last_vertex
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // dir_code, zero pad
	output logic [M_USER_W-1:0] m_tuser,   // closing_edge, span_error
	output logic                m_tlast    // run_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_STEP  = 2'd2;

	logic [1:0] state_q;
	logic       have_vertex_q;
	logic       closing_q;
	logic       close_pend_q;

	logic [COORD_BITS-1:0] first_x_q;
	logic [COORD_BITS-1:0] first_y_q;
	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic [COORD_BITS-1:0] ex0_q;
	logic [COORD_BITS-1:0] ey0_q;
	logic [COORD_BITS-1:0] ex1_q;
	logic [COORD_BITS-1:0] ey1_q;

	logic       m_valid_q;
	logic [2:0] code_q;
	logic       closing_out_q;
	logic       err_q;
	logic       last_q;

	logic [COORD_BITS-1:0] in_x;
	logic [COORD_BITS-1:0] in_y;
	logic                  accept;
	logic                  out_free;
	logic                  emit;
	logic                  emit_err;
	logic                  advance;
	logic                  item_end;
	logic [2:0]            dda_code;
	logic                  dda_last;
	edge_info_t            info;
	dda_ctl_t              dda_ctl;

	pcc_edge_calc u_calc (
		.x0   (ex0_q),
		.y0   (ey0_q),
		.x1   (ex1_q),
		.y1   (ey1_q),
		.info (info)
	);

	pcc_dda u_dda (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dda_ctl),
		.info      (info),
		.code      (dda_code),
		.last_step (dda_last)
	);

	always_comb begin
		in_x     = s_tdata[COORD_BITS-1:0];
		in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
		s_tready = (state_q == ST_IDLE);
		accept   = s_tvalid && s_tready;
		out_free = !m_valid_q || m_tready;
		item_end = closing_q || !close_pend_q;

		emit         = 1'b0;
		emit_err     = 1'b0;
		advance      = 1'b0;
		dda_ctl.load = 1'b0;
		dda_ctl.step = 1'b0;
		case (state_q)
			ST_SETUP: begin
				if (info.zero) begin
					advance = 1'b1;
				end else if (info.too_long) begin
					emit_err = out_free;
					advance  = out_free;
				end else begin
					dda_ctl.load = 1'b1;
				end
			end
			ST_STEP: begin
				emit         = out_free;
				dda_ctl.step = out_free;
				advance      = out_free && dda_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			have_vertex_q <= 1'b0;
			closing_q     <= 1'b0;
			close_pend_q  <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (emit || emit_err) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (have_vertex_q) begin
							state_q       <= ST_SETUP;
							closing_q     <= 1'b0;
							close_pend_q  <= s_tlast && ((in_x != first_x_q) ||
							                             (in_y != first_y_q));
							have_vertex_q <= !s_tlast;
						end else begin
							// a lone closing vertex has a zero-length closing edge
							have_vertex_q <= !s_tlast;
						end
					end
				end
				ST_SETUP: begin
					if (dda_ctl.load) begin
						state_q <= ST_STEP;
					end else if (advance) begin
						if (!closing_q && close_pend_q) begin
							closing_q    <= 1'b1;
							close_pend_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STEP: begin
					if (advance) begin
						if (!closing_q && close_pend_q) begin
							state_q      <= ST_SETUP;
							closing_q    <= 1'b1;
							close_pend_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// vertex and edge endpoint registers
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			ex0_q    <= prev_x_q;
			ey0_q    <= prev_y_q;
			ex1_q    <= in_x;
			ey1_q    <= in_y;
			if (!have_vertex_q) begin
				first_x_q <= in_x;
				first_y_q <= in_y;
			end
		end else if (advance && !closing_q && close_pend_q) begin
			// load the closing edge: current vertex back to the first one
			ex0_q <= prev_x_q;
			ey0_q <= prev_y_q;
			ex1_q <= first_x_q;
			ey1_q <= first_y_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q        <= dda_code;
			closing_out_q <= closing_q;
			err_q         <= 1'b0;
			last_q        <= dda_last && item_end;
		end else if (emit_err) begin
			code_q        <= DIR_E;
			closing_out_q <= closing_q;
			err_q         <= 1'b1;
			last_q        <= item_end;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'(code_q);
	assign m_tuser  = {err_q, closing_out_q};
	assign m_tlast  = last_q;

endmodule
